@@ hw/rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and the rotate helper for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned NumWord = 16;
    localparam int unsigned NumHash = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       put_byte;    // store the input byte, bump the length
        logic       put_pad;     // store one padding byte at the fill position
        logic       put_len;     // store one length byte at the fill position
        logic       load_vars;   // copy chain value into working variables
        logic       round;       // run one compression round
        logic       add_chain;   // add working variables into chain value
        logic       clear_msg;   // restore initial hash, clear length
        logic       pad_first;   // padding byte is 0x80 rather than zero
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic [5:0] fill_pos;    // byte position within the block
        logic       last_round;  // round counter at 63
    } t_status;

    localparam logic [31:0] InitHash [NumHash] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sha_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer with rolling schedule, working variables, chain value and
// message length counter.
// ----------------------------------------------------------------------------
module sha_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sha_pkg::t_cmd    i_cmd,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [2:0]       i_out_idx,
    output sha_pkg::t_status      o_status,
    output logic [31:0]           o_hash_word
);
    import sha_pkg::*;

    logic [31:0] r_win [NumWord];
    logic [31:0] r_var [NumHash];
    logic [31:0] r_chain [NumHash];
    logic [63:0] r_len;
    logic [63:0] r_len_snap;
    logic [5:0]  r_pos;
    logic [5:0]  r_round;

    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [31:0] w_new, w_cur, t1, t2;
    logic [31:0] s0, s1, e_sig, a_sig, ch, maj;
    logic [2:0]  len_sel;

    assign len_sel = r_pos[2:0];

    always_comb begin
        wr_en   = i_cmd.put_byte | i_cmd.put_pad | i_cmd.put_len;
        wr_byte = 8'h00;
        if (i_cmd.put_byte) begin
            wr_byte = i_data_byte;
        end else if (i_cmd.put_pad) begin
            wr_byte = i_cmd.pad_first ? 8'h80 : 8'h00;
        end else if (i_cmd.put_len) begin
            wr_byte = r_len_snap[(7 - len_sel) * 8 +: 8];
        end
    end

    // Schedule word: first 16 rounds read the block, later ones extend it.
    always_comb begin
        s1 = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        s0 = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        w_new = s1 + r_win[9] + s0 + r_win[0];
        w_cur = (r_round < 6'd16) ? r_win[0] : w_new;
        e_sig = rotr(r_var[4], 6) ^ rotr(r_var[4], 11) ^ rotr(r_var[4], 25);
        a_sig = rotr(r_var[0], 2) ^ rotr(r_var[0], 13) ^ rotr(r_var[0], 22);
        ch    = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        maj   = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        t1    = r_var[7] + e_sig + ch + RoundK[r_round] + w_cur;
        t2    = a_sig + maj;
    end

    // Window rotates by one word a round, so word 0 is always the current one.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_win[r_pos[5:2]][(3 - r_pos[1:0]) * 8 +: 8] <= wr_byte;
        end else if (i_cmd.round) begin
            for (int i = 0; i < NumWord - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[NumWord - 1] <= w_cur;
        end
        if (i_cmd.load_vars) begin
            r_var <= r_chain;
        end else if (i_cmd.round) begin
            for (int i = 1; i < NumHash; i++) begin
                if (i != 4) begin
                    r_var[i] <= r_var[i - 1];
                end
            end
            r_var[4] <= r_var[3] + t1;
            r_var[0] <= t1 + t2;
        end
        if (i_cmd.put_pad && i_cmd.pad_first) begin
            r_len_snap <= r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= InitHash;
            r_len   <= '0;
            r_pos   <= '0;
            r_round <= '0;
        end else begin
            if (i_cmd.clear_msg) begin
                r_chain <= InitHash;
                r_len   <= '0;
                r_pos   <= '0;
            end else begin
                if (i_cmd.add_chain) begin
                    for (int i = 0; i < NumHash; i++) begin
                        r_chain[i] <= r_chain[i] + r_var[i];
                    end
                end
                if (i_cmd.put_byte) begin
                    r_len <= r_len + 64'd8;
                end
                if (wr_en) begin
                    r_pos <= r_pos + 6'd1;
                end
            end
            if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
        end
    end

    assign o_status.fill_pos   = r_pos;
    assign o_status.last_round = (r_round == 6'd63);
    assign o_hash_word         = r_chain[i_out_idx];

endmodule
`default_nettype wire

@@ hw/rtl/sha_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_byte_valid,
    input  wire logic             i_message_end,
    input  wire sha_pkg::t_status i_status,
    output sha_pkg::t_cmd         o_cmd,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [2:0]            o_out_idx
);
    import sha_pkg::*;

    t_state r_state, n_state;
    logic   r_fin, n_fin;          // finishing a message
    logic   r_pad1, n_pad1;        // 0x80 byte already placed
    logic   r_lenph, n_lenph;      // writing length bytes
    logic [2:0] r_idx, n_idx;
    logic   take;

    assign take = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_pad1  = r_pad1;
        n_lenph = r_lenph;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    if (i_byte_valid && i_status.fill_pos == 6'd63) begin
                        n_state = ST_LOAD;
                        n_fin   = i_message_end;
                    end else if (i_message_end) begin
                        n_state = ST_PAD;
                        n_fin   = 1'b1;
                    end
                    n_pad1  = 1'b0;
                    n_lenph = 1'b0;
                end
            end
            ST_PAD: begin
                if (!r_pad1) begin
                    n_pad1 = 1'b1;
                    if (i_status.fill_pos == 6'd63) begin
                        n_state = ST_LOAD;
                    end else if (i_status.fill_pos == 6'd55) begin
                        n_lenph = 1'b1;
                    end
                end else if (r_lenph) begin
                    if (i_status.fill_pos == 6'd63) begin
                        n_state = ST_LOAD;
                    end
                end else begin
                    if (i_status.fill_pos == 6'd63) begin
                        n_state = ST_LOAD;
                    end else if (i_status.fill_pos == 6'd55) begin
                        n_lenph = 1'b1;
                    end
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: begin
                if (i_status.last_round) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_lenph) begin
                    n_state = ST_OUT;
                    n_idx   = 3'd0;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = ST_IDLE;
                        n_fin   = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.put_byte = take && i_byte_valid;
            end
            ST_PAD: begin
                o_cmd.put_pad   = !r_lenph;
                o_cmd.pad_first = !r_pad1;
                o_cmd.put_len   = r_lenph;
            end
            ST_LOAD:  o_cmd.load_vars = 1'b1;
            ST_ROUND: o_cmd.round     = 1'b1;
            ST_ADD:   o_cmd.add_chain = 1'b1;
            ST_OUT: begin
                o_valid         = 1'b1;
                o_cmd.clear_msg = i_ready && (r_idx == 3'd7);
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
            r_pad1  <= 1'b0;
            r_lenph <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_pad1  <= n_pad1;
            r_lenph <= n_lenph;
            r_idx   <= n_idx;
        end
    end

    assign o_out_idx = r_idx;

endmodule
`default_nettype wire

@@ hw/rtl/sha256_message_hasher_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-serial SHA-256 with standard padding and an eight-word digest output.
// ----------------------------------------------------------------------------
// Bytes enter at one per cycle while idle; a full block adds a compression
// (load, 64 rounds, chain add), one round per cycle through a single round unit.
// Message end adds up to 72 padding and length bytes and one or two compressions,
// then eight digest words leave at one per cycle while the consumer is ready.
// Synchronous active-low reset restores the initial hash and a zero length.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_message_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    import sha_pkg::*;

    t_cmd       cmd;
    t_status    status;
    logic [2:0] out_idx;

    // The controller walks intake, padding, rounds and output; the datapath
    // holds all message state and performs the arithmetic.
    sha_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_valid  (i_byte_valid),
        .i_message_end (i_message_end),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_idx     (out_idx)
    );

    sha_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .i_out_idx   (out_idx),
        .o_status    (status),
        .o_hash_word (o_digest_word)
    );

    // The digest is read straight out of the chain registers, which hold
    // still until the last word is taken.
    assign o_word_index = out_idx;
    assign o_last_word  = (out_idx == 3'd7);

endmodule
`default_nettype wire
